@@ hdl/pm_sensor_frame_parser_defines.svh @@
// Assertion helpers for the dust sensor frame parser.
`ifndef PM_SENSOR_FRAME_PARSER_DEFINES_SVH
`define PM_SENSOR_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication.
`define PMSFP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PMSFP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pmsfp_pkg.sv @@
package pmsfp_pkg;

  localparam logic [7:0] HdrFirst  = 8'hFE;
  localparam logic [7:0] HdrSecond = 8'hA5;

  localparam int unsigned PosW = 4;
  localparam logic [PosW-1:0] PosHunt     = 4'd0;
  localparam logic [PosW-1:0] PosHdr2     = 4'd1;
  localparam logic [PosW-1:0] PosBody     = 4'd2;
  localparam logic [PosW-1:0] PosPayFirst = 4'd4;
  localparam logic [PosW-1:0] PosCsum     = 4'd10;

  localparam int unsigned PayBytes = 6;
  localparam int unsigned PayIdxW  = $clog2(PayBytes);

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgPm25Level = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgPm10Level = 2'd1;

  localparam logic [15:0] Pm25LevelRst = 16'd75;
  localparam logic [15:0] Pm10LevelRst = 16'd150;

  localparam int unsigned QueueDepthDef = 2;

  typedef struct packed {
    logic [15:0] pm1;
    logic [15:0] pm25;
    logic [15:0] pm10;
    logic        ok;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

@@ hdl/pmsfp_front.sv @@
module pmsfp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  input  pmsfp_pkg::queue_stat_t q_stat_i,
  output logic                push_o,
  output pmsfp_pkg::frame_t   frame_o
);

  logic [pmsfp_pkg::PosW-1:0] pos_q, pos_d;
  logic [7:0]                 sum_q, sum_d;
  logic [7:0]                 pay_q [pmsfp_pkg::PayBytes];
  logic [pmsfp_pkg::PosW-1:0] pay_off;
  logic                       accept;

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign pay_off    = pos_q - pmsfp_pkg::PosPayFirst;

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    if (accept) begin
      priority if (pos_q == pmsfp_pkg::PosHunt) begin
        if (rx_byte_i == pmsfp_pkg::HdrFirst) pos_d = pmsfp_pkg::PosHdr2;
      end else if (pos_q == pmsfp_pkg::PosHdr2) begin
        if (rx_byte_i == pmsfp_pkg::HdrSecond) begin
          sum_d = rx_byte_i;
          pos_d = pmsfp_pkg::PosBody;
        end else if (rx_byte_i == pmsfp_pkg::HdrFirst) begin
          pos_d = pmsfp_pkg::PosHdr2;
        end else begin
          pos_d = pmsfp_pkg::PosHunt;
        end
      end else if (pos_q < pmsfp_pkg::PosCsum) begin
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + 4'd1;
      end else begin
        sum_d = 8'd0;
        pos_d = pmsfp_pkg::PosHunt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= pmsfp_pkg::PosHunt;
      sum_q <= 8'd0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pos_q >= pmsfp_pkg::PosPayFirst && pos_q < pmsfp_pkg::PosCsum) begin
      pay_q[pay_off[pmsfp_pkg::PayIdxW-1:0]] <= rx_byte_i;
    end
  end

  assign push_o        = accept && (pos_q >= pmsfp_pkg::PosCsum);
  assign frame_o.pm1   = {pay_q[0], pay_q[1]};
  assign frame_o.pm25  = {pay_q[2], pay_q[3]};
  assign frame_o.pm10  = {pay_q[4], pay_q[5]};
  assign frame_o.ok    = (sum_q == rx_byte_i);

endmodule

@@ hdl/pmsfp_queue.sv @@
module pmsfp_queue #(
  parameter int unsigned Depth = pmsfp_pkg::QueueDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  pmsfp_pkg::frame_t      frame_i,
  input  logic                   pop_i,
  output pmsfp_pkg::frame_t      frame_o,
  output pmsfp_pkg::queue_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  pmsfp_pkg::frame_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntFull);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign frame_o      = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= frame_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      if (do_pop)  rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ hdl/pmsfp_back.sv @@
module pmsfp_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pmsfp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [15:0]                     cfg_data_i,
  input  pmsfp_pkg::frame_t               frame_i,
  input  pmsfp_pkg::queue_stat_t          q_stat_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [15:0]                     pm1_value_o,
  output logic [15:0]                     pm25_value_o,
  output logic [15:0]                     pm10_value_o,
  output logic                            pm25_alarm_o,
  output logic                            pm10_alarm_o,
  output logic                            checksum_ok_o
);

  logic [15:0] pm25_lvl_q, pm10_lvl_q;
  logic [15:0] pm1_q, pm25_q, pm10_q;
  logic        alarm25_q, alarm10_q, ok_q, valid_q;

  assign cfg_ready_o = 1'b1;
  assign pop_o       = !q_stat_i.empty && (!valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm25_lvl_q <= pmsfp_pkg::Pm25LevelRst;
      pm10_lvl_q <= pmsfp_pkg::Pm10LevelRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == pmsfp_pkg::CfgPm25Level) pm25_lvl_q <= cfg_data_i;
      if (cfg_index_i == pmsfp_pkg::CfgPm10Level) pm10_lvl_q <= cfg_data_i;
    end
  end

  // Stored readings double as the output payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm1_q     <= 16'd0;
      pm25_q    <= 16'd0;
      pm10_q    <= 16'd0;
      alarm25_q <= 1'b0;
      alarm10_q <= 1'b0;
      ok_q      <= 1'b0;
      valid_q   <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      ok_q    <= frame_i.ok;
      if (frame_i.ok) begin
        pm1_q     <= frame_i.pm1;
        pm25_q    <= frame_i.pm25;
        pm10_q    <= frame_i.pm10;
        alarm25_q <= (frame_i.pm25 >= pm25_lvl_q);
        alarm10_q <= (frame_i.pm10 >= pm10_lvl_q);
      end
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = valid_q;
  assign pm1_value_o   = pm1_q;
  assign pm25_value_o  = pm25_q;
  assign pm10_value_o  = pm10_q;
  assign pm25_alarm_o  = alarm25_q;
  assign pm10_alarm_o  = alarm10_q;
  assign checksum_ok_o = ok_q;

endmodule

@@ hdl/pm_sensor_frame_parser.sv @@
// Channel  | Handshake             | Payload
// ---------+-----------------------+------------------------------------------
// input    | in_valid_i/in_stall_o | rx_byte_i
// output   | out_valid_o/out_stall_i | pm1/pm25/pm10_value_o, alarms, checksum_ok_o
// config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One byte per cycle while in_stall_o is low. A frame's result goes into the frame queue
// with its checksum byte, then into the output register, which raises out_valid_o.
// rst_ni is asynchronous; no clearing pass, the block takes bytes right away.
// in_stall_o rises only while the frame queue holds QueueDepth results.
// cfg_ready_o is always high.
module pm_sensor_frame_parser #(
  parameter int unsigned QueueDepth = pmsfp_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [15:0]                   pm1_value_o,
  output logic [15:0]                   pm25_value_o,
  output logic [15:0]                   pm10_value_o,
  output logic                          pm25_alarm_o,
  output logic                          pm10_alarm_o,
  output logic                          checksum_ok_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pmsfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);

  pmsfp_pkg::frame_t      push_frame, pop_frame;
  pmsfp_pkg::queue_stat_t q_stat;
  logic                   push, pop;

  pmsfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .frame_o    (push_frame)
  );

  pmsfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (push_frame),
    .pop_i   (pop),
    .frame_o (pop_frame),
    .stat_o  (q_stat)
  );

  pmsfp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .frame_i       (pop_frame),
    .q_stat_i      (q_stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pm1_value_o   (pm1_value_o),
    .pm25_value_o  (pm25_value_o),
    .pm10_value_o  (pm10_value_o),
    .pm25_alarm_o  (pm25_alarm_o),
    .pm10_alarm_o  (pm10_alarm_o),
    .checksum_ok_o (checksum_ok_o)
  );

endmodule

@@ hdl/pmsfp_checker.sv @@
`include "pm_sensor_frame_parser_defines.svh"

module pmsfp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [15:0]                   pm1_value_o,
  input logic [15:0]                   pm25_value_o,
  input logic [15:0]                   pm10_value_o,
  input logic                          pm25_alarm_o,
  input logic                          pm10_alarm_o,
  input logic                          checksum_ok_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [pmsfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input logic [15:0]                   cfg_data_i
);

  logic [15:0] lvl25_q, lvl10_q;
  logic [15:0] last_pm1_q, last_pm25_q, last_pm10_q;
  logic        last_a25_q, last_a10_q;
  logic        out_xfer;

  assign out_xfer = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl25_q     <= pmsfp_pkg::Pm25LevelRst;
      lvl10_q     <= pmsfp_pkg::Pm10LevelRst;
      last_pm1_q  <= 16'd0;
      last_pm25_q <= 16'd0;
      last_pm10_q <= 16'd0;
      last_a25_q  <= 1'b0;
      last_a10_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == pmsfp_pkg::CfgPm25Level) lvl25_q <= cfg_data_i;
        if (cfg_index_i == pmsfp_pkg::CfgPm10Level) lvl10_q <= cfg_data_i;
      end
      if (out_xfer) begin
        last_pm1_q  <= pm1_value_o;
        last_pm25_q <= pm25_value_o;
        last_pm10_q <= pm10_value_o;
        last_a25_q  <= pm25_alarm_o;
        last_a10_q  <= pm10_alarm_o;
      end
    end
  end

  `PMSFP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(pm25_value_o) && $stable(checksum_ok_o), "stalled result changed")

  `PMSFP_ASSERT_IMP(a_alarm25, clk_i, rst_ni, out_valid_o && checksum_ok_o,
    pm25_alarm_o == (pm25_value_o >= lvl25_q), "PM2.5 alarm mismatch")

  `PMSFP_ASSERT_IMP(a_alarm10, clk_i, rst_ni, out_valid_o && checksum_ok_o,
    pm10_alarm_o == (pm10_value_o >= lvl10_q), "PM10 alarm mismatch")

  `PMSFP_ASSERT_IMP(a_bad_keeps, clk_i, rst_ni, out_valid_o && !checksum_ok_o,
    pm1_value_o == last_pm1_q && pm25_value_o == last_pm25_q &&
    pm10_value_o == last_pm10_q && pm25_alarm_o == last_a25_q &&
    pm10_alarm_o == last_a10_q, "bad frame changed readings")

endmodule

bind pm_sensor_frame_parser pmsfp_checker u_pmsfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pm1_value_o   (pm1_value_o),
  .pm25_value_o  (pm25_value_o),
  .pm10_value_o  (pm10_value_o),
  .pm25_alarm_o  (pm25_alarm_o),
  .pm10_alarm_o  (pm10_alarm_o),
  .checksum_ok_o (checksum_ok_o),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .cfg_index_i   (cfg_index_i),
  .cfg_data_i    (cfg_data_i)
);

@@ dv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pmsfp_pkg::*;

  localparam int FrameLen = PosCsum + 1;
  localparam int IdleLimit = 3000;
  localparam logic [CfgIdxW-1:0] CfgSpare0 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpare1 = 2'd3;

  typedef struct {
    logic [15:0] pm1;
    logic [15:0] pm25;
    logic [15:0] pm10;
    logic        alarm25;
    logic        alarm10;
    logic        ok;
  } pm_result_t;

  logic                 clk = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic [7:0]           rx_byte = 8'h00;
  logic                 out_stall = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [15:0]          cfg_data = 16'h0000;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [15:0]          pm1_value_o;
  logic [15:0]          pm25_value_o;
  logic [15:0]          pm10_value_o;
  logic                 pm25_alarm_o;
  logic                 pm10_alarm_o;
  logic                 checksum_ok_o;
  logic                 cfg_ready_o;

  // parser state
  logic [PosW-1:0] frame_pos = PosHunt;
  logic [7:0]      frame_sum = 8'h00;
  logic [7:0]      pm_bytes [PayBytes];
  logic [15:0]     held_pm1 = 16'h0000;
  logic [15:0]     held_pm25 = 16'h0000;
  logic [15:0]     held_pm10 = 16'h0000;
  logic            held_alarm25 = 1'b0;
  logic            held_alarm10 = 1'b0;
  logic [15:0]     lvl_pm25 = Pm25LevelRst;
  logic [15:0]     lvl_pm10 = Pm10LevelRst;

  pm_result_t frames_due[$];

  int  mismatches = 0;
  int  bytes_sent = 0;
  int  frames_seen = 0;
  int  frames_rejected = 0;
  int  input_stall_cycles = 0;
  int  hold_left = 0;
  int  rx_gap = 0;
  int  idle_cycles = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;

  pm_sensor_frame_parser dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall),
    .pm1_value_o  (pm1_value_o),
    .pm25_value_o (pm25_value_o),
    .pm10_value_o (pm10_value_o),
    .pm25_alarm_o (pm25_alarm_o),
    .pm10_alarm_o (pm10_alarm_o),
    .checksum_ok_o(checksum_ok_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void parse_byte(input logic [7:0] b);
    pm_result_t r;
    case (frame_pos)
      PosHunt: begin
        if (b == HdrFirst) frame_pos = PosHdr2;
      end
      PosHdr2: begin
        if (b == HdrSecond) begin
          frame_sum = b;
          frame_pos = PosBody;
        end else begin
          frame_pos = (b == HdrFirst) ? PosHdr2 : PosHunt;
        end
      end
      PosCsum: begin
        r.ok = (frame_sum == b);
        if (r.ok) begin
          held_pm1 = {pm_bytes[0], pm_bytes[1]};
          held_pm25 = {pm_bytes[2], pm_bytes[3]};
          held_pm10 = {pm_bytes[4], pm_bytes[5]};
          held_alarm25 = (held_pm25 >= lvl_pm25);
          held_alarm10 = (held_pm10 >= lvl_pm10);
        end
        frame_pos = PosHunt;
        frame_sum = 8'h00;
        r.pm1 = held_pm1;
        r.pm25 = held_pm25;
        r.pm10 = held_pm10;
        r.alarm25 = held_alarm25;
        r.alarm10 = held_alarm10;
        frames_due.push_back(r);
      end
      default: begin
        frame_sum = frame_sum + b;
        if (frame_pos >= PosPayFirst) pm_bytes[frame_pos - PosPayFirst] = b;
        frame_pos = frame_pos + 1'b1;
      end
    endcase
  endfunction

  // Leaves valid high on return; the caller lowers it via stop_input if nothing follows.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do begin
      @(posedge clk);
      if (in_stall_o) input_stall_cycles++;
    end while (in_stall_o);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [15:0] pm1, input logic [15:0] pm25,
                            input logic [15:0] pm10, input bit corrupt, input int n);
    logic [7:0] fr [FrameLen];
    logic [7:0] csum;
    fr[0] = HdrFirst;
    fr[1] = HdrSecond;
    fr[2] = 8'($urandom_range(0, 255));
    fr[3] = 8'($urandom_range(0, 255));
    fr[4] = pm1[15:8];
    fr[5] = pm1[7:0];
    fr[6] = pm25[15:8];
    fr[7] = pm25[7:0];
    fr[8] = pm10[15:8];
    fr[9] = pm10[7:0];
    csum = 8'h00;
    for (int j = 1; j < PosCsum; j++) csum = csum + fr[j];
    if (corrupt) csum = csum + 8'($urandom_range(1, 255));
    fr[PosCsum] = csum;
    for (int j = 0; j < n; j++) send_byte(fr[j]);
  endtask

  function automatic logic [15:0] pick_pm(input logic [15:0] lvl);
    logic [15:0] v;
    case ($urandom_range(0, 6))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2: v = lvl;
      3: v = lvl - 1'b1;
      4: v = lvl + 1'b1;
      default: v = 16'($urandom_range(0, 65535));
    endcase
    return v;
  endfunction

  task automatic quiesce();
    while (frames_due.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == CfgPm25Level) lvl_pm25 = val;
    else if (idx == CfgPm10Level) lvl_pm10 = val;
    @(posedge clk);
  endtask

  task automatic set_levels(input logic [15:0] l25, input logic [15:0] l10);
    quiesce();
    write_reg(CfgPm25Level, l25);
    write_reg(CfgPm10Level, l10);
    write_reg($urandom_range(0, 1) ? CfgSpare0 : CfgSpare1, 16'($urandom_range(0, 65535)));
  endtask

  task automatic run_random(input int units);
    int k;
    logic [7:0] b;
    for (int i = 0; i < units; i++) begin
      tx_burst = ($urandom_range(0, 4) == 0);
      k = $urandom_range(0, 99);
      if (k < 72) begin
        send_frame(pick_pm(lvl_pm25), pick_pm(lvl_pm25), pick_pm(lvl_pm10), 1'b0, FrameLen);
      end else if (k < 84) begin
        send_frame(pick_pm(lvl_pm25), pick_pm(lvl_pm25), pick_pm(lvl_pm10), 1'b1, FrameLen);
      end else if (k < 90) begin
        repeat ($urandom_range(1, 5)) begin
          b = ($urandom_range(0, 3) == 0) ? HdrFirst : 8'($urandom_range(0, 255));
          send_byte(b);
        end
      end else if (k < 95) begin
        send_byte(HdrFirst);
        do b = 8'($urandom_range(0, 255)); while (b == HdrSecond);
        send_byte(b);
      end else begin
        send_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 1'b0, $urandom_range(3, PosCsum));
      end
    end
    tx_burst = 1'b0;
    stop_input();
  endtask

  // stray bytes, wrong second header byte, repeated first header byte, boundary alarms
  task automatic test_header_hunt();
    send_byte(8'h00);
    send_byte(HdrSecond);
    send_byte(8'hFF);
    send_byte(HdrFirst);
    send_byte(8'h13);
    send_byte(HdrFirst);
    send_frame(16'hFFFF, Pm25LevelRst, Pm10LevelRst - 1'b1, 1'b0, FrameLen);
    stop_input();
  endtask

  // new thresholds must not touch the held alarms on a rejected frame
  task automatic test_rejected_frame();
    set_levels(16'hFFFF, 16'h0000);
    send_frame(16'h0000, 16'h0000, 16'h0000, 1'b1, FrameLen);
    stop_input();
  endtask

  task automatic test_threshold_sweep();
    set_levels(Pm25LevelRst, Pm10LevelRst);
    run_random(13);
    set_levels(16'h0000, 16'h0000);
    run_random(13);
    set_levels(16'hFFFF, 16'hFFFF);
    run_random(13);
    repeat (2) begin
      set_levels(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      run_random(13);
    end
  endtask

  // long receiver hold with back-to-back frames fills the result queue
  task automatic test_back_pressure();
    quiesce();
    hold_left = 300;
    tx_burst = 1'b1;
    repeat (7) begin
      send_frame(pick_pm(lvl_pm25), pick_pm(lvl_pm25), pick_pm(lvl_pm10), 1'b0, FrameLen);
    end
    tx_burst = 1'b0;
    stop_input();
  endtask

  always @(posedge clk) begin
    pm_result_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      frames_seen++;
      if (checksum_ok_o !== 1'b1) frames_rejected++;
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result pm1=%h pm25=%h pm10=%h ok=%b",
                                  pm1_value_o, pm25_value_o, pm10_value_o, checksum_ok_o));
      end else begin
        want = frames_due.pop_front();
        if (pm1_value_o !== want.pm1)
          report_mismatch($sformatf("frame %0d pm1 %h, want %h", frames_seen, pm1_value_o,
                                    want.pm1));
        if (pm25_value_o !== want.pm25)
          report_mismatch($sformatf("frame %0d pm25 %h, want %h", frames_seen, pm25_value_o,
                                    want.pm25));
        if (pm10_value_o !== want.pm10)
          report_mismatch($sformatf("frame %0d pm10 %h, want %h", frames_seen, pm10_value_o,
                                    want.pm10));
        if (pm25_alarm_o !== want.alarm25)
          report_mismatch($sformatf("frame %0d pm25 alarm %b, want %b", frames_seen,
                                    pm25_alarm_o, want.alarm25));
        if (pm10_alarm_o !== want.alarm10)
          report_mismatch($sformatf("frame %0d pm10 alarm %b, want %b", frames_seen,
                                    pm10_alarm_o, want.alarm10));
        if (checksum_ok_o !== want.ok)
          report_mismatch($sformatf("frame %0d checksum_ok %b, want %b", frames_seen,
                                    checksum_ok_o, want.ok));
      end
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      rx_gap = rx_burst ? 0 : $urandom_range(0, 17);
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || (cfg_valid && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_header_hunt();
    test_rejected_frame();
    test_threshold_sweep();
    test_back_pressure();
    quiesce();
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes over several threshold settings; checked %0d frames, %0d rejected.",
             bytes_sent, frames_seen, frames_rejected);
    $display("Input held off for %0d cycles under receiver back-pressure.", input_stall_cycles);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
